[hdl/dmmn_pkg.sv]
// Shared types and constants for the depth min/max to 8-bit gray normalizer.
package dmmn_pkg;

    localparam int PIXEL_W   = 16;
    localparam int GRAY_BITS = 8;
    localparam logic [GRAY_BITS-1:0] GRAY_MIN = '0;
    localparam logic [GRAY_BITS-1:0] GRAY_MAX = '1;

    // Values of the kind field.
    localparam logic KIND_SCAN = 1'b0;
    localparam logic KIND_MAP  = 1'b1;

    typedef struct packed {
        logic               kind;
        logic               first_of_pass;
        logic               last_of_pass;
        logic [PIXEL_W-1:0] pixel;
    } in_t;

    typedef struct packed {
        logic [GRAY_BITS-1:0] gray;
        logic                 frame_end;
    } out_t;

endpackage

[hdl/dmmn_extremes.sv]
// Minimum and maximum tracker for the nonzero samples of a scan pass.
module dmmn_extremes #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  upd,
    input  logic                  first,
    input  logic [PIXEL_BITS-1:0] pix,
    output logic [PIXEL_BITS-1:0] lo,
    output logic [PIXEL_BITS-1:0] hi
);

    logic [PIXEL_BITS-1:0] lo_reg, lo_next;
    logic [PIXEL_BITS-1:0] hi_reg, hi_next;
    logic [PIXEL_BITS-1:0] lo_base, hi_base;

    always_comb begin
        // A first flag restarts the extremes before this sample is taken in.
        lo_base = first ? '1 : lo_reg;
        hi_base = first ? '0 : hi_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (upd) begin
            lo_next = lo_base;
            hi_next = hi_base;
            if (pix != '0) begin
                if (pix < lo_base) begin
                    lo_next = pix;
                end
                if (pix > hi_base) begin
                    hi_next = pix;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg <= '1;
            hi_reg <= '0;
        end else begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

[hdl/dmmn_divider.sv]
// Restoring divider that develops an 8-bit quotient one bit per cycle.
module dmmn_divider #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [PIXEL_BITS+8:0]                num,
    input  logic [PIXEL_BITS:0]                  den,
    output logic                                 done,
    output logic [dmmn_pkg::GRAY_BITS-1:0]       quo
);

    localparam int NUM_W = PIXEL_BITS + 9;
    localparam int QB    = dmmn_pkg::GRAY_BITS;
    localparam int CNT_W = $clog2(QB);

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dsh_reg, dsh_next;
    logic [QB-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             fits;

    assign fits = (rem_reg >= dsh_reg);

    always_comb begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            // The quotient is known to stay below 2**QB, so the divisor starts
            // aligned to the top quotient bit.
            rem_next  = num;
            dsh_next  = NUM_W'({den, {(QB-1){1'b0}}});
            cnt_next  = CNT_W'(QB - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = rem_reg - dsh_reg;
            end
            quo_next = {quo_reg[QB-2:0], fits};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[hdl/depth_minmax_normalize_to_gray8.sv]
// Depth normalizer: a frame is sent twice, a scan pass (kind 0) that gathers the
// smallest and largest nonzero sample and returns nothing, then a map pass
// (kind 1) that returns one gray value per sample, round((v-min)*255/(max-min))
// rounded half up and clamped, 0 for a zero sample, with min=0 and max=1 when
// max<=min. A map sample goes from acceptance to a loaded result through a
// setup step, the bit-serial restoring divider (one quotient bit at a time), a
// step to pick up the quotient, then the hand-off to the output register;
// samples that need no division (zero, at or beyond the extremes, or a
// degenerate range) skip the divider. The next sample is accepted in the cycle
// after the hand-off. The output register lets the next sample be accepted
// while a result still waits to be taken.
module depth_minmax_normalize_to_gray8 #(
    parameter int PIXEL_BITS = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  dmmn_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output dmmn_pkg::out_t  m_data
);

    localparam int NUM_W = PIXEL_BITS + 9;
    localparam int QB    = dmmn_pkg::GRAY_BITS;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [PIXEL_BITS-1:0] pix_reg, pix_next;
    logic                  last_reg, last_next;
    logic [QB-1:0]         gray_reg, gray_next;
    logic                  m_valid_reg, m_valid_next;
    dmmn_pkg::out_t        m_data_reg, m_data_next;

    logic                  s_fire;
    logic                  scan_upd;
    logic [PIXEL_BITS-1:0] in_pix;
    logic [PIXEL_BITS-1:0] lo_w, hi_w;
    logic [PIXEL_BITS-1:0] lo_eff, hi_eff, range_w, diff_w;
    logic [NUM_W-1:0]      num_w;
    logic [PIXEL_BITS:0]   den_w;
    logic                  div_start, div_done;
    logic [QB-1:0]         div_quo;
    logic                  degen, out_load;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign in_pix   = s_data.pixel[PIXEL_BITS-1:0];
    assign scan_upd = s_fire && (s_data.kind == dmmn_pkg::KIND_SCAN);

    dmmn_extremes #(.PIXEL_BITS(PIXEL_BITS)) u_extremes (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (scan_upd),
        .first   (s_data.first_of_pass),
        .pix     (in_pix),
        .lo      (lo_w),
        .hi      (hi_w)
    );

    // Setup of the division: num = (v-lo)*510 + range, den = 2*range.
    always_comb begin
        degen   = (hi_w <= lo_w);
        lo_eff  = degen ? '0 : lo_w;
        hi_eff  = degen ? PIXEL_BITS'(1) : hi_w;
        range_w = hi_eff - lo_eff;
        diff_w  = pix_reg - lo_eff;
        num_w   = NUM_W'({diff_w, 9'b0}) - NUM_W'({diff_w, 1'b0}) + NUM_W'(range_w);
        den_w   = {range_w, 1'b0};
    end

    dmmn_divider #(.PIXEL_BITS(PIXEL_BITS)) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_w),
        .den     (den_w),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        pix_next     = pix_reg;
        last_next    = last_reg;
        gray_next    = gray_reg;
        div_start    = 1'b0;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_data.kind == dmmn_pkg::KIND_MAP)) begin
                    pix_next   = in_pix;
                    last_next  = s_data.last_of_pass;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (pix_reg == '0 || pix_reg <= lo_eff) begin
                    gray_next  = dmmn_pkg::GRAY_MIN;
                    state_next = ST_DONE;
                end else if (pix_reg >= hi_eff) begin
                    gray_next  = dmmn_pkg::GRAY_MAX;
                    state_next = ST_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    gray_next  = div_quo;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    m_data_next.gray      = gray_reg;
                    m_data_next.frame_end = last_reg;
                    m_valid_next          = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        pix_reg    <= pix_next;
        last_reg   <= last_next;
        gray_reg   <= gray_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The divider reports completion only while a division is awaited.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside of a division");

    // After a nonzero scan sample the extremes bracket it, so min <= max.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (scan_upd && (in_pix != '0)) |=> (lo_w <= hi_w))
        else $error("extremes out of order after a nonzero scan sample");

    // A result appears only from the hand-off state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised without a finished map transaction");

endmodule
